// File: design/isr_pkg.sv
// Package for the integer square root core: widths, stage split and the
// pipeline payload type. No dependencies.
`default_nettype none

package isr_pkg;

  localparam int unsigned IN_WIDTH        = 32;
  localparam int unsigned ROOT_W          = 16;
  localparam int unsigned STEPS_PER_STAGE = 4;
  localparam int unsigned ROOT_BITS       = (IN_WIDTH + 1) / 2;
  localparam int unsigned NUM_STAGES      = (ROOT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned FULL_ROOT       = NUM_STAGES * STEPS_PER_STAGE;
  localparam int unsigned PAD_W           = 2 * FULL_ROOT;
  localparam int unsigned REM_W           = FULL_ROOT + 2;

  typedef logic [IN_WIDTH-1:0]  radicand_t;
  typedef logic [ROOT_W-1:0]    root_out_t;
  typedef logic [PAD_W-1:0]     pad_rad_t;
  typedef logic [FULL_ROOT-1:0] full_root_t;
  typedef logic [REM_W-1:0]     rem_t;

  typedef struct packed {
    pad_rad_t   rad;
    full_root_t root;
    rem_t       rem;
  } stage_t;

endpackage

`default_nettype wire

// File: design/isr_stage.sv
// One pipeline stage of the square root core: STEPS_PER_STAGE restoring
// digit steps followed by an elastic register. Depends on isr_pkg.
`default_nettype none

module isr_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire isr_pkg::stage_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output isr_pkg::stage_t     data_o
);

  logic            valid_q;
  isr_pkg::stage_t data_q;
  isr_pkg::stage_t data_d;

  always_comb begin
    isr_pkg::stage_t       cur;
    isr_pkg::rem_t         rem_shift;
    isr_pkg::rem_t         trial;
    logic [isr_pkg::REM_W:0] diff;
    cur = data_i;
    for (int unsigned s = 0; s < isr_pkg::STEPS_PER_STAGE; s++) begin
      rem_shift = {cur.rem[isr_pkg::REM_W-3:0], cur.rad[isr_pkg::PAD_W-1 -: 2]};
      trial     = {cur.root, 2'b01};
      diff      = {1'b0, rem_shift} - {1'b0, trial};
      cur.rad   = {cur.rad[isr_pkg::PAD_W-3:0], 2'b00};
      if (!diff[isr_pkg::REM_W]) begin
        cur.rem  = diff[isr_pkg::REM_W-1:0];
        cur.root = {cur.root[isr_pkg::FULL_ROOT-2:0], 1'b1};
      end else begin
        cur.rem  = rem_shift;
        cur.root = {cur.root[isr_pkg::FULL_ROOT-2:0], 1'b0};
      end
    end
    data_d = cur;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// File: design/integer_square_root_core.sv
// Top level of the integer square root core: a chain of isr_stage
// instances. Depends on isr_pkg and isr_stage.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one unsigned radicand_i
//   (IN_WIDTH bits) per transaction. Output channel out_valid_o/out_ready_i
//   returns root_o = floor(sqrt(radicand_i)), one transaction per input,
//   in order.
//   Each accepted radicand passes in order through the NUM_STAGES stage
//   registers before out_valid_o rises, and the result is taken while
//   out_ready_i is high. Each stage resolves four root bits with four
//   chained narrow subtract-and-compare steps.
//   Throughput: one transaction per cycle while out_ready_i stays high.
//   Stall: when out_ready_i is low the last stage holds its result; earlier
//   stages keep filling their empty slots, and in_ready_o drops only once
//   every stage holds a transaction. Nothing is lost or repeated.
//   Reset: rst_ni (asynchronous, active low) empties the pipeline; no
//   transactions are in flight afterward and no clearing pass is needed.
`default_nettype none

module integer_square_root_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire isr_pkg::radicand_t radicand_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output isr_pkg::root_out_t      root_o
);

  logic            valid_s [isr_pkg::NUM_STAGES+1];
  logic            ready_s [isr_pkg::NUM_STAGES+1];
  isr_pkg::stage_t data_s  [isr_pkg::NUM_STAGES+1];

  assign valid_s[0] = in_valid_i;
  assign in_ready_o = ready_s[0];
  assign data_s[0]  = '{rad: isr_pkg::pad_rad_t'(radicand_i), root: '0, rem: '0};

  for (genvar g = 0; g < isr_pkg::NUM_STAGES; g++) begin : g_stage
    isr_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[g]),
      .ready_o (ready_s[g]),
      .data_i  (data_s[g]),
      .valid_o (valid_s[g+1]),
      .ready_i (ready_s[g+1]),
      .data_o  (data_s[g+1])
    );
  end

  assign ready_s[isr_pkg::NUM_STAGES] = out_ready_i;
  assign out_valid_o = valid_s[isr_pkg::NUM_STAGES];
  assign root_o      = isr_pkg::root_out_t'(data_s[isr_pkg::NUM_STAGES].root);

endmodule

`default_nettype wire
